>>> rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// PAM fluorescence parameters: shared package
// Widths, constants and the sideband records that travel next to the
// divider chains of the pixel pipeline.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // Sample width and fraction bits of the ratio outputs.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned FracBits = 16;

  // Quotient bits of the Fo' divider and of the ratio dividers.
  localparam int unsigned Div1QW = 25;
  localparam int unsigned Div2QW = 48;

  // Fv'/(Fm'+0.0001) is scaled as Fv' * 10000 * 2^(FracBits-8) / (10000*Fm' + 1).
  localparam int unsigned EffScale = 10000;
  localparam int unsigned EffMul   = EffScale * (1 << (FracBits - 8));

  // Guard for a zero Fm' in Y(II) and NPQ: divide by 0.1, i.e. multiply by 10.
  localparam int unsigned GuardMul = 10;

  // Record that rides along the Fo' divider.
  typedef struct packed {
    logic [SampleW-1:0] fo;
    logic [SampleW-1:0] fm;
    logic [SampleW-1:0] ft;
    logic [SampleW-1:0] fm1;
    logic               d_zero;
    logic               c_unit;
    logic               n_neg;
  } pfp_s2_t;

  // Record that rides along the ratio dividers.
  typedef struct packed {
    logic signed [16:0] fv;
    logic signed [25:0] fo1;
    logic signed [26:0] fv1;
    logic signed [16:0] fq;
    logic               eff_neg;
    logic               yld_neg;
    logic               npq_neg;
    logic               qn_neg;
    logic               d_zero;
    logic               dq_zero;
    logic               drop_pos;
    logic               drop_neg;
  } pfp_s4_t;

endpackage

>>> rtl/pfp_div_cell.sv
// ----------------------------------------------------------------------------
// PAM fluorescence parameters: divider cell
// One restoring division step: shifts in one numerator bit, compares with
// the divisor and hands remainder, quotient and operands to the next cell.
// ----------------------------------------------------------------------------
module pfp_div_cell #(
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   num_i,
  input  logic [Q_W-1:0]   quo_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [Q_W-1:0]   num_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [DEN_W-1:0] den_o
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem_i, num_i[Q_W-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Hand the step result to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      num_o <= {num_i[Q_W-2:0], 1'b0};
      quo_o <= {quo_i[Q_W-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule

>>> rtl/pfp_divider.sv
// ----------------------------------------------------------------------------
// PAM fluorescence parameters: pipelined divider
// A chain of Q_W division cells, one quotient bit per cell. The numerator
// must be below the divisor times 2^Q_W. Rounding is left to the user, who
// gets the final remainder and divisor.
// ----------------------------------------------------------------------------
module pfp_divider #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o
);

  logic [DEN_W-1:0] rem_s [Q_W+1];
  logic [Q_W-1:0]   num_s [Q_W+1];
  logic [Q_W-1:0]   quo_s [Q_W+1];
  logic [DEN_W-1:0] den_s [Q_W+1];

  // Remainder starts as the high numerator bits; user must keep them < divisor.
  generate
    if (NUM_W > Q_W) begin : g_high
      assign rem_s[0] = DEN_W'(num_i[NUM_W-1:Q_W]);
    end else begin : g_nohigh
      assign rem_s[0] = '0;
    end
  endgenerate

  assign num_s[0] = num_i[Q_W-1:0];
  assign quo_s[0] = '0;
  assign den_s[0] = den_i;

  // Row of identical cells.
  generate
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
      pfp_div_cell #(
        .DEN_W(DEN_W),
        .Q_W  (Q_W)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (en_i),
        .rem_i(rem_s[k]),
        .num_i(num_s[k]),
        .quo_i(quo_s[k]),
        .den_i(den_s[k]),
        .rem_o(rem_s[k+1]),
        .num_o(num_s[k+1]),
        .quo_o(quo_s[k+1]),
        .den_o(den_s[k+1])
      );
    end
  endgenerate

  assign quo_o = quo_s[Q_W];
  assign rem_o = rem_s[Q_W];
  assign den_o = den_s[Q_W];

endmodule

>>> rtl/pfp_delay.sv
// ----------------------------------------------------------------------------
// PAM fluorescence parameters: sideband delay line
// Carries a record alongside a divider chain so that it arrives together
// with the quotient.
// ----------------------------------------------------------------------------
module pfp_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] tap_q [DEPTH];

  // Shift one place per advancing cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

>>> rtl/pam_fluorescence_params_unit.sv
// ----------------------------------------------------------------------------
// PAM fluorescence parameters unit
// Throughput: one pixel per cycle; set by the two chains of division cells
// (25 cells for Fo', 48 cells for the ratios), one quotient bit per cell.
// The whole pipeline advances together and holds while a result waits.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module pam_fluorescence_params_unit
  import pfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        fo_sample_i,
  input  logic [15:0]        fm_sample_i,
  input  logic [15:0]        ft_sample_i,
  input  logic [15:0]        fm1_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] variable_dark_o,
  output logic signed [25:0] minimal_light_o,
  output logic signed [26:0] variable_light_o,
  output logic signed [16:0] quenched_light_o,
  output logic signed [31:0] efficiency_light_o,
  output logic signed [31:0] yield_psii_o,
  output logic signed [31:0] npq_value_o,
  output logic signed [31:0] qn_value_o,
  output logic               zero_divisor_o
);

  localparam int unsigned VldN = 2 + Div1QW + 2 + Div2QW;

  // Rounded magnitude quotient, signed and saturated to 32 bits.
  function automatic logic signed [31:0] sat_q(input logic [Div2QW-1:0] quo,
                                               input logic rnd, input logic neg);
    logic [Div2QW:0] q;
    q = (Div2QW+1)'(quo) + (Div2QW+1)'(rnd);
    if (neg) begin
      if (q >= (Div2QW+1)'(64'h8000_0000)) sat_q = 32'sh8000_0000;
      else                                  sat_q = 32'((Div2QW+1)'(0) - q);
    end else begin
      if (q > (Div2QW+1)'(64'h7FFF_FFFF)) sat_q = 32'sh7FFF_FFFF;
      else                                 sat_q = q[31:0];
    end
    return sat_q;
  endfunction

  logic            en;
  logic [VldN-1:0] vld_q;
  logic            out_valid_q;

  // Global advance: move when the output register is free or being taken.
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[VldN-2:0], in_valid_i};
      out_valid_q <= vld_q[VldN-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products for c = N/D.
  // --------------------------------------------------------------------------
  logic signed [16:0] fv0;
  logic [15:0]        s1_fo_q, s1_fm_q, s1_ft_q, s1_fm1_q;
  logic [31:0]        s1_d_q, s1_pb_q;
  logic signed [33:0] s1_pa_q;

  assign fv0 = $signed({1'b0, fm_sample_i}) - $signed({1'b0, fo_sample_i});

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_fo_q  <= fo_sample_i;
      s1_fm_q  <= fm_sample_i;
      s1_ft_q  <= ft_sample_i;
      s1_fm1_q <= fm1_sample_i;
      s1_d_q   <= 32'(fm_sample_i) * 32'(fm1_sample_i);
      s1_pb_q  <= 32'(fo_sample_i) * 32'(fm_sample_i);
      s1_pa_q  <= 34'(fv0) * 34'($signed({1'b0, fm1_sample_i}));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: N, its magnitude, the case of c and the Fo' numerator.
  // --------------------------------------------------------------------------
  logic signed [33:0] n_s;
  logic [33:0]        n_neg_v;
  logic [32:0]        nmag;
  pfp_s2_t            s2_d, s2_q;
  logic [55:0]        s2_num_q;
  logic [32:0]        s2_den_q;

  always_comb begin
    n_s        = s1_pa_q + $signed({2'b00, s1_pb_q});
    n_neg_v    = 34'd0 - n_s;
    nmag       = n_s[33] ? n_neg_v[32:0] : n_s[32:0];
    s2_d.fo    = s1_fo_q;
    s2_d.fm    = s1_fm_q;
    s2_d.ft    = s1_ft_q;
    s2_d.fm1   = s1_fm1_q;
    s2_d.d_zero = (s1_d_q == 32'd0);
    s2_d.c_unit = (nmag < {1'b0, s1_d_q});
    s2_d.n_neg = n_s[33];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q     <= s2_d;
      s2_num_q <= {48'(s1_fo_q) * 48'(s1_d_q), 8'd0};
      s2_den_q <= nmag;
    end
  end

  // Fo' magnitude division and its sideband.
  logic [Div1QW-1:0] quo1;
  logic [32:0]       rem1, den1;
  logic [$bits(pfp_s2_t)-1:0] s2_dly;
  pfp_s2_t           s2_out;

  pfp_divider #(
    .NUM_W(56),
    .DEN_W(33),
    .Q_W  (Div1QW)
  ) u_div_fo1 (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(s2_num_q),
    .den_i(s2_den_q),
    .quo_o(quo1),
    .rem_o(rem1),
    .den_o(den1)
  );

  pfp_delay #(
    .W    ($bits(pfp_s2_t)),
    .DEPTH(Div1QW)
  ) u_dly_s2 (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i(s2_q),
    .data_o(s2_dly)
  );

  assign s2_out = pfp_s2_t'(s2_dly);

  // --------------------------------------------------------------------------
  // Stage 3: Fo', Fv', the qN divisor and the integer differences.
  // --------------------------------------------------------------------------
  logic               rnd1;
  logic [25:0]        q1;
  logic signed [25:0] fo1_d;
  logic signed [25:0] s3_fo1_q;
  logic signed [26:0] s3_fv1_q, s3_dq_q;
  logic signed [16:0] s3_fv_q, s3_fq_q, s3_drop_q;
  logic [15:0]        s3_fm1_q;
  logic               s3_d_zero_q;

  always_comb begin
    rnd1 = ({rem1, 1'b0} >= {1'b0, den1});
    q1   = 26'(quo1) + 26'(rnd1);
    if (s2_out.d_zero)      fo1_d = '0;
    else if (s2_out.c_unit) fo1_d = $signed({2'b00, s2_out.fo, 8'd0});
    else if (s2_out.n_neg)  fo1_d = $signed(26'd0 - q1);
    else                    fo1_d = $signed(q1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_fo1_q    <= fo1_d;
      s3_fv1_q    <= $signed({3'b000, s2_out.fm1, 8'd0}) - 27'(fo1_d);
      s3_dq_q     <= $signed({3'b000, s2_out.fm, 8'd0}) - 27'(fo1_d);
      s3_fv_q     <= $signed({1'b0, s2_out.fm}) - $signed({1'b0, s2_out.fo});
      s3_fq_q     <= $signed({1'b0, s2_out.fm1}) - $signed({1'b0, s2_out.ft});
      s3_drop_q   <= $signed({1'b0, s2_out.fm}) - $signed({1'b0, s2_out.fm1});
      s3_fm1_q    <= s2_out.fm1;
      s3_d_zero_q <= s2_out.d_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes, guarded divisors and signs of the four ratios.
  // --------------------------------------------------------------------------
  logic [26:0]       fv1_neg_v, dq_neg_v;
  logic [16:0]       fq_neg_v, drop_neg_v;
  logic [25:0]       fv1_mag, dq_mag;
  logic [15:0]       fq_mag, drop_mag;
  logic              fm1_zero;
  logic [19:0]       fq_scaled, drop_scaled;
  pfp_s4_t           s4_d, s4_q;
  logic [Div2QW-1:0] eff_num_q, yld_num_q, npq_num_q, qn_num_q;
  logic [29:0]       eff_den_q;
  logic [15:0]       yld_den_q;
  logic [25:0]       qn_den_q;

  always_comb begin
    fv1_neg_v   = 27'd0 - s3_fv1_q;
    dq_neg_v    = 27'd0 - s3_dq_q;
    fq_neg_v    = 17'd0 - s3_fq_q;
    drop_neg_v  = 17'd0 - s3_drop_q;
    fv1_mag     = s3_fv1_q[26] ? fv1_neg_v[25:0] : s3_fv1_q[25:0];
    dq_mag      = s3_dq_q[26] ? dq_neg_v[25:0] : s3_dq_q[25:0];
    fq_mag      = s3_fq_q[16] ? fq_neg_v[15:0] : s3_fq_q[15:0];
    drop_mag    = s3_drop_q[16] ? drop_neg_v[15:0] : s3_drop_q[15:0];
    fm1_zero    = (s3_fm1_q == 16'd0);
    fq_scaled   = fm1_zero ? 20'(fq_mag) * 20'(GuardMul) : 20'(fq_mag);
    drop_scaled = fm1_zero ? 20'(drop_mag) * 20'(GuardMul) : 20'(drop_mag);

    s4_d.fv       = s3_fv_q;
    s4_d.fo1      = s3_fo1_q;
    s4_d.fv1      = s3_fv1_q;
    s4_d.fq       = s3_fq_q;
    s4_d.eff_neg  = s3_fv1_q[26];
    s4_d.yld_neg  = s3_fq_q[16];
    s4_d.npq_neg  = s3_drop_q[16];
    s4_d.qn_neg   = s3_drop_q[16] ^ s3_dq_q[26];
    s4_d.d_zero   = s3_d_zero_q;
    s4_d.dq_zero  = (s3_dq_q == 27'sd0);
    s4_d.drop_pos = !s3_drop_q[16] && (s3_drop_q != 17'sd0);
    s4_d.drop_neg = s3_drop_q[16];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q      <= s4_d;
      eff_num_q <= Div2QW'(fv1_mag) * Div2QW'(EffMul);
      eff_den_q <= 30'(s3_fm1_q) * 30'(EffScale) + 30'd1;
      yld_num_q <= Div2QW'({fq_scaled, 16'd0});
      npq_num_q <= Div2QW'({drop_scaled, 16'd0});
      yld_den_q <= fm1_zero ? 16'd1 : s3_fm1_q;
      qn_num_q  <= Div2QW'({drop_mag, 24'd0});
      qn_den_q  <= dq_mag;
    end
  end

  // Ratio dividers, all of equal length so their results line up.
  logic [Div2QW-1:0] eff_quo, yld_quo, npq_quo, qn_quo;
  logic [29:0]       eff_rem, eff_den;
  logic [15:0]       yld_rem, yld_den, npq_rem, npq_den;
  logic [25:0]       qn_rem, qn_den;
  logic [$bits(pfp_s4_t)-1:0] s4_dly;
  pfp_s4_t           s4_out;

  pfp_divider #(.NUM_W(Div2QW), .DEN_W(30), .Q_W(Div2QW)) u_div_eff (
    .clk_i(clk_i), .en_i(en), .num_i(eff_num_q), .den_i(eff_den_q),
    .quo_o(eff_quo), .rem_o(eff_rem), .den_o(eff_den)
  );

  pfp_divider #(.NUM_W(Div2QW), .DEN_W(16), .Q_W(Div2QW)) u_div_yld (
    .clk_i(clk_i), .en_i(en), .num_i(yld_num_q), .den_i(yld_den_q),
    .quo_o(yld_quo), .rem_o(yld_rem), .den_o(yld_den)
  );

  pfp_divider #(.NUM_W(Div2QW), .DEN_W(16), .Q_W(Div2QW)) u_div_npq (
    .clk_i(clk_i), .en_i(en), .num_i(npq_num_q), .den_i(yld_den_q),
    .quo_o(npq_quo), .rem_o(npq_rem), .den_o(npq_den)
  );

  pfp_divider #(.NUM_W(Div2QW), .DEN_W(26), .Q_W(Div2QW)) u_div_qn (
    .clk_i(clk_i), .en_i(en), .num_i(qn_num_q), .den_i(qn_den_q),
    .quo_o(qn_quo), .rem_o(qn_rem), .den_o(qn_den)
  );

  pfp_delay #(
    .W    ($bits(pfp_s4_t)),
    .DEPTH(Div2QW)
  ) u_dly_s4 (
    .clk_i (clk_i),
    .en_i  (en),
    .data_i(s4_q),
    .data_o(s4_dly)
  );

  assign s4_out = pfp_s4_t'(s4_dly);

  // --------------------------------------------------------------------------
  // Output register: rounding, saturation and the zero divisor cases.
  // --------------------------------------------------------------------------
  logic               eff_rnd, yld_rnd, npq_rnd, qn_rnd;
  logic signed [31:0] qn_d;

  always_comb begin
    eff_rnd = ({eff_rem, 1'b0} >= {1'b0, eff_den});
    yld_rnd = ({yld_rem, 1'b0} >= {1'b0, yld_den});
    npq_rnd = ({npq_rem, 1'b0} >= {1'b0, npq_den});
    qn_rnd  = ({qn_rem, 1'b0} >= {1'b0, qn_den});
    if (s4_out.dq_zero) begin
      if (s4_out.drop_pos)      qn_d = 32'sh7FFF_FFFF;
      else if (s4_out.drop_neg) qn_d = 32'sh8000_0000;
      else                      qn_d = '0;
    end else begin
      qn_d = sat_q(qn_quo, qn_rnd, s4_out.qn_neg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      variable_dark_o    <= s4_out.fv;
      minimal_light_o    <= s4_out.fo1;
      variable_light_o   <= s4_out.fv1;
      quenched_light_o   <= s4_out.fq;
      efficiency_light_o <= sat_q(eff_quo, eff_rnd, s4_out.eff_neg);
      yield_psii_o       <= sat_q(yld_quo, yld_rnd, s4_out.yld_neg);
      npq_value_o        <= sat_q(npq_quo, npq_rnd, s4_out.npq_neg);
      qn_value_o         <= qn_d;
      zero_divisor_o     <= s4_out.d_zero | s4_out.dq_zero;
    end
  end

endmodule
